/* src/dnd_pkg.sv */
`timescale 1ns / 1ps

package dnd_pkg;

    localparam int STORE_DEPTH = 512;
    localparam int NAME_MAX    = 255;

    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int POS_W      = 15;                      // 14-bit pointer target or store end
    localparam int LEN_W      = $clog2(NAME_MAX + 1);
    localparam int CHARS_PER  = 8;
    localparam int WIDX_W     = LEN_W - 3;
    localparam int NAME_WORDS = 2 ** WIDX_W;
    localparam int LIMIT_W    = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
    localparam logic [7:0]         CHAR_DOT    = 8'h2E;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PTR   = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic       op;
        logic [8:0] address;
        logic [7:0] byte_value;
    } t_in;

    typedef struct packed {
        logic [63:0] name_chars;
        logic [3:0]  char_count;
        logic        last;
        logic [8:0]  consumed;
        logic [1:0]  status;
    } t_out;

    // walker -> emitter
    typedef struct packed {
        logic       append;
        logic [7:0] ch;
        logic       finish;
        logic [1:0] status;
        logic [8:0] consumed;
    } t_walk_evt;

    typedef enum logic [1:0] {
        W_IDLE,
        W_WALK,
        W_PTR
    } t_walk_state;

    typedef enum logic [1:0] {
        E_COLLECT,
        E_READ,
        E_SHOW
    } t_emit_state;

endpackage

/* src/dnd_walk.sv */
`timescale 1ns / 1ps

module dnd_walk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic                         i_start,
    input  logic [8:0]                   i_addr,
    input  logic [7:0]                   i_byte,
    input  logic [dnd_pkg::LIMIT_W-1:0]  i_limit,
    input  logic [dnd_pkg::LEN_W-1:0]    i_len,
    output logic                         o_idle,
    output dnd_pkg::t_walk_evt           o_evt
);
    import dnd_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] r_rdata;

    t_walk_state r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_start, n_start;
    logic [7:0]         r_rem, n_rem;
    logic [LIMIT_W-1:0] r_ptrs, n_ptrs;
    logic               r_jumped, n_jumped;
    logic [8:0]         r_cons, n_cons;
    logic [5:0]         r_hi, n_hi;

    logic [POS_W-1:0] addr_ext;
    logic             pos_out;
    logic             len_full;
    logic             is_ptr;
    logic [POS_W-1:0] here_cons;

    assign addr_ext  = POS_W'(i_addr);
    assign pos_out   = r_pos >= POS_W'(STORE_DEPTH);
    assign len_full  = i_len >= LEN_W'(NAME_MAX);
    assign is_ptr    = r_rdata[7:6] == 2'b11;
    assign here_cons = r_pos - r_start;

    // While a walk runs, r_rdata holds the store byte at r_pos whenever r_pos lies inside the store
    always_ff @(posedge i_clk) begin
        if (i_load && addr_ext < POS_W'(STORE_DEPTH)) begin
            mem[addr_ext[ADDR_W-1:0]] <= i_byte;
        end
        r_rdata <= mem[n_pos[ADDR_W-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_state = W_WALK;
                end
            end
            W_WALK: begin
                if (pos_out) begin
                    n_state = W_IDLE;
                end else if (r_rem != 8'd0) begin
                    if (len_full) begin
                        n_state = W_IDLE;
                    end
                end else if (r_rdata == 8'd0) begin
                    n_state = W_IDLE;
                end else if (is_ptr) begin
                    if (r_pos == POS_W'(STORE_DEPTH - 1) || r_ptrs >= i_limit) begin
                        n_state = W_IDLE;
                    end else begin
                        n_state = W_PTR;
                    end
                end else if (i_len != '0 && len_full) begin
                    n_state = W_IDLE;
                end
            end
            W_PTR: begin
                n_state = W_WALK;
            end
            default: n_state = W_IDLE;
        endcase
    end

    always_comb begin
        n_pos    = r_pos;
        n_start  = r_start;
        n_rem    = r_rem;
        n_ptrs   = r_ptrs;
        n_jumped = r_jumped;
        n_cons   = r_cons;
        n_hi     = r_hi;
        o_evt    = '0;
        unique case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_pos    = addr_ext;
                    n_start  = addr_ext;
                    n_rem    = 8'd0;
                    n_ptrs   = '0;
                    n_jumped = 1'b0;
                    n_cons   = 9'd0;
                end
            end
            W_WALK: begin
                if (pos_out) begin
                    o_evt.finish = 1'b1;
                    o_evt.status = ST_RANGE;
                end else if (r_rem != 8'd0) begin
                    if (len_full) begin
                        o_evt.finish = 1'b1;
                        o_evt.status = ST_LONG;
                    end else begin
                        o_evt.append = 1'b1;
                        o_evt.ch     = r_rdata;
                        n_pos        = r_pos + 1'b1;
                        n_rem        = r_rem - 8'd1;
                    end
                end else if (r_rdata == 8'd0) begin
                    o_evt.finish   = 1'b1;
                    o_evt.status   = ST_OK;
                    o_evt.consumed = r_jumped ? r_cons : here_cons[8:0] + 9'd1;
                end else if (is_ptr) begin
                    if (r_pos == POS_W'(STORE_DEPTH - 1)) begin
                        o_evt.finish = 1'b1;
                        o_evt.status = ST_RANGE;
                    end else if (r_ptrs >= i_limit) begin
                        o_evt.finish = 1'b1;
                        o_evt.status = ST_PTR;
                    end else begin
                        if (!r_jumped) begin
                            n_cons   = here_cons[8:0] + 9'd2;
                            n_jumped = 1'b1;
                        end
                        n_ptrs = r_ptrs + 1'b1;
                        n_hi   = r_rdata[5:0];
                        n_pos  = r_pos + 1'b1;
                    end
                end else if (i_len != '0 && len_full) begin
                    o_evt.finish = 1'b1;
                    o_evt.status = ST_LONG;
                end else begin
                    // new label: separator first unless this is the first label
                    o_evt.append = i_len != '0;
                    o_evt.ch     = CHAR_DOT;
                    n_rem        = r_rdata;
                    n_pos        = r_pos + 1'b1;
                end
            end
            W_PTR: begin
                n_pos = POS_W'({r_hi, r_rdata});
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pos    <= n_pos;
        r_start  <= n_start;
        r_rem    <= n_rem;
        r_ptrs   <= n_ptrs;
        r_jumped <= n_jumped;
        r_cons   <= n_cons;
        r_hi     <= n_hi;
    end

    assign o_idle = r_state == W_IDLE;

endmodule

/* src/dnd_emit.sv */
`timescale 1ns / 1ps

module dnd_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dnd_pkg::t_walk_evt         i_evt,
    input  logic                       i_out_ready,
    output logic [dnd_pkg::LEN_W-1:0]  o_len,
    output logic                       o_idle,
    output logic                       o_out_valid,
    output dnd_pkg::t_out              o_out
);
    import dnd_pkg::*;

    logic [63:0] mem [NAME_WORDS];
    logic [63:0] r_rd;

    t_emit_state r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [63:0]       r_word, n_word;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic [1:0]        r_status, n_status;
    logic [8:0]        r_cons, n_cons;
    logic              r_single, n_single;

    logic [2:0]        lane;
    logic              wr_en;
    logic [WIDX_W-1:0] wr_addr;
    logic [63:0]       wr_data;
    logic [LEN_W-1:0]  len_m1;
    logic              last_word;
    logic              fail_or_empty;

    assign lane          = r_len[2:0];
    assign len_m1        = r_len - 1'b1;
    assign last_word     = r_single || r_widx == len_m1[LEN_W-1:3];
    assign fail_or_empty = i_evt.status != ST_OK || r_len == '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (r_state == E_READ) begin
            r_rd <= mem[r_widx];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            E_COLLECT: begin
                if (i_evt.finish) begin
                    n_state = fail_or_empty ? E_SHOW : E_READ;
                end
            end
            E_READ: n_state = E_SHOW;
            E_SHOW: begin
                if (i_out_ready) begin
                    n_state = last_word ? E_COLLECT : E_READ;
                end
            end
            default: n_state = E_COLLECT;
        endcase
    end

    always_comb begin
        n_len    = r_len;
        n_word   = r_word;
        n_widx   = r_widx;
        n_status = r_status;
        n_cons   = r_cons;
        n_single = r_single;
        wr_en    = 1'b0;
        wr_addr  = r_len[LEN_W-1:3];
        wr_data  = r_word;
        unique case (r_state)
            E_COLLECT: begin
                if (i_evt.append) begin
                    n_word = (lane == 3'd0 ? 64'd0 : r_word)
                             | (64'(i_evt.ch) << {lane, 3'b000});
                    n_len  = r_len + 1'b1;
                    // word complete: store it
                    if (lane == 3'd7) begin
                        wr_en   = 1'b1;
                        wr_data = n_word;
                    end
                end else if (i_evt.finish) begin
                    n_status = i_evt.status;
                    n_cons   = i_evt.status == ST_OK ? i_evt.consumed : 9'd0;
                    n_single = fail_or_empty;
                    n_widx   = '0;
                    // flush the partial last word
                    wr_en    = !fail_or_empty && lane != 3'd0;
                end
            end
            E_READ: begin
            end
            E_SHOW: begin
                if (i_out_ready) begin
                    if (last_word) begin
                        n_len = '0;
                    end else begin
                        n_widx = r_widx + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_out            = '0;
        o_out_valid      = r_state == E_SHOW;
        o_out.last       = last_word;
        if (!r_single) begin
            o_out.name_chars = r_rd;
            o_out.char_count = (last_word && lane != 3'd0) ? {1'b0, lane} : 4'(CHARS_PER);
        end
        if (last_word) begin
            o_out.consumed = r_cons;
            o_out.status   = r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_COLLECT;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
        r_word   <= n_word;
        r_widx   <= n_widx;
        r_status <= n_status;
        r_cons   <= n_cons;
        r_single <= n_single;
    end

    assign o_len  = r_len;
    assign o_idle = r_state == E_COLLECT;

endmodule

/* src/dns_name_decompressor.sv */
`timescale 1ns / 1ps
// A decode walks the store one byte at a time (length, label and end bytes), with an extra
// pointer step for each pointer's second byte, paced by the single store read port; each
// result then takes a buffer read and a show step.
// A lone empty or error result skips the buffer read. Ready is low until the last result is taken.
// Synchronous active-low reset sets pointer_limit to 16 and idles both sequencers;
// the message store is not cleared.

module dns_name_decompressor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  dnd_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dnd_pkg::t_out               o_out,
    input  logic                        i_cfg_we,
    input  logic [dnd_pkg::LIMIT_W-1:0] i_cfg_data
);
    import dnd_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               in_fire;
    logic               walk_idle;
    logic               emit_idle;
    logic [LEN_W-1:0]   name_len;
    t_walk_evt          evt;

    assign o_in_ready = walk_idle && emit_idle;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    dnd_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_fire && i_in.op == OP_LOAD),
        .i_start (in_fire && i_in.op == OP_DECODE),
        .i_addr  (i_in.address),
        .i_byte  (i_in.byte_value),
        .i_limit (r_limit),
        .i_len   (name_len),
        .o_idle  (walk_idle),
        .o_evt   (evt)
    );

    dnd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_out_ready (i_out_ready),
        .o_len       (name_len),
        .o_idle      (emit_idle),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    a_decode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.op == OP_DECODE) |=> !o_in_ready)
        else $error("ready right after a decode transaction");

    a_error_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |-> (o_out.last && o_out.char_count == 4'd0))
        else $error("error result carries characters");

    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last) |-> o_out.char_count == 4'(CHARS_PER))
        else $error("non-final result not full");

endmodule

/* verif/tb_dns_name_decompressor.sv */
`timescale 1ns / 1ps

module tb_dns_name_decompressor;
    import dnd_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [7:0] PTR_TAG = 8'hC0;

    // Tracks the message store and limit as seen through accepted transactions,
    // expands names and holds the name words still owed by the block.
    class name_scoreboard;
        logic [7:0]         store_bytes [STORE_DEPTH];
        bit                 store_written [STORE_DEPTH];
        logic [LIMIT_W-1:0] pointer_limit;
        t_out               pending_words [$];
        int                 errors;
        int                 loads;
        int                 decodes;
        int                 words;
        int                 status_hits [4];

        function new();
            pointer_limit = LIMIT_RESET;
            errors = 0;
            loads = 0;
            decodes = 0;
            words = 0;
            foreach (store_written[i]) store_written[i] = 1'b0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        // Returns 0 when the walk would read a byte that was never loaded.
        function bit walk_name(input int start, output t_out name_words [$]);
            logic [7:0] text [NAME_MAX+1];
            int         pos;
            int         len;
            int         ptrs;
            int         cons;
            int         lb;
            int         i;
            int         base;
            int         n;
            bit         jumped;
            bit         done;
            logic [1:0] st;
            t_out       w;
            name_words = {};
            pos = start;
            len = 0;
            ptrs = 0;
            cons = 0;
            jumped = 1'b0;
            done = 1'b0;
            st = ST_OK;
            while (!done && st == ST_OK) begin
                if (pos >= STORE_DEPTH) begin
                    st = ST_RANGE;
                end else if (!store_written[pos]) begin
                    return 1'b0;
                end else begin
                    lb = int'(store_bytes[pos]);
                    if (lb == 0) begin
                        if (!jumped) cons = pos - start + 1;
                        done = 1'b1;
                    end else if (lb >= int'(PTR_TAG)) begin
                        if (pos + 1 >= STORE_DEPTH) begin
                            st = ST_RANGE;
                        end else if (!store_written[pos+1]) begin
                            return 1'b0;
                        end else if (ptrs >= int'(pointer_limit)) begin
                            st = ST_PTR;
                        end else begin
                            // in-place length stops at the first pointer
                            if (!jumped) begin
                                cons = pos - start + 2;
                                jumped = 1'b1;
                            end
                            ptrs++;
                            pos = ((lb & 'h3F) << 8) | int'(store_bytes[pos+1]);
                        end
                    end else begin
                        if (len != 0) begin
                            if (len + 1 > NAME_MAX) begin
                                st = ST_LONG;
                            end else begin
                                text[len] = CHAR_DOT;
                                len++;
                            end
                        end
                        for (i = 1; i <= lb && st == ST_OK; i++) begin
                            if (pos + i >= STORE_DEPTH) begin
                                st = ST_RANGE;
                            end else if (!store_written[pos+i]) begin
                                return 1'b0;
                            end else if (len + 1 > NAME_MAX) begin
                                st = ST_LONG;
                            end else begin
                                text[len] = store_bytes[pos+i];
                                len++;
                            end
                        end
                        pos += lb + 1;
                    end
                end
            end

            if (st != ST_OK) begin
                w = '0;
                w.last = 1'b1;
                w.status = st;
                name_words.push_back(w);
            end else if (len == 0) begin
                w = '0;
                w.last = 1'b1;
                w.consumed = 9'(cons);
                name_words.push_back(w);
            end else begin
                for (base = 0; base < len; base += CHARS_PER) begin
                    n = (len - base > CHARS_PER) ? CHARS_PER : len - base;
                    w = '0;
                    for (i = 0; i < n; i++) w.name_chars[8*i +: 8] = text[base+i];
                    w.char_count = 4'(n);
                    if (base + n >= len) begin
                        w.last = 1'b1;
                        w.consumed = 9'(cons);
                    end
                    name_words.push_back(w);
                end
            end
            return 1'b1;
        endfunction

        function void note_input(t_in item);
            t_out name_words [$];
            if (item.op == OP_LOAD) begin
                store_bytes[item.address] = item.byte_value;
                store_written[item.address] = 1'b1;
                loads++;
            end else begin
                void'(walk_name(int'(item.address), name_words));
                decodes++;
                status_hits[name_words[name_words.size()-1].status]++;
                foreach (name_words[i]) pending_words.push_back(name_words[i]);
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_words.size() == 0) begin
                $error("unexpected name word: %h", got);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            words++;
            if (got.name_chars !== want.name_chars) begin
                $error("name_chars: expected %h, got %h", want.name_chars, got.name_chars);
                errors++;
            end
            if (got.char_count !== want.char_count) begin
                $error("char_count: expected %0d, got %0d", want.char_count, got.char_count);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (got.consumed !== want.consumed) begin
                $error("consumed: expected %0d, got %0d", want.consumed, got.consumed);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in                i_in;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out               o_out;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_data;

    name_scoreboard sb;
    int             cycles = 0;
    int             burst_left = 0;
    int             items_sent = 0;
    int             stall_mode = 0;
    int             stall_left = 0;
    int             name_starts [$];

    dns_name_decompressor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: check accepted words, then pick ready from the current stall mode.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 1) == 1);
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (stall_left % 3 != 0);
        endcase
    end

    // Sender runs in bursts; between bursts a random gap may drop valid.
    task automatic send(input t_in item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(item);
        items_sent++;
    endtask

    task automatic load(input int addr, input logic [7:0] value);
        t_in item;
        item.op = OP_LOAD;
        item.address = 9'(addr);
        item.byte_value = value;
        send(item);
    endtask

    task automatic load_label(input int addr, input int label_len);
        int i;
        load(addr, 8'(label_len));
        for (i = 1; i <= label_len; i++) load(addr + i, 8'($urandom));
    endtask

    task automatic decode(input int addr);
        t_out scratch [$];
        t_in  item;
        // never start a walk that would hit a byte still undefined in the store
        if (!sb.walk_name(addr, scratch)) return;
        item.op = OP_DECODE;
        item.address = 9'(addr);
        item.byte_value = 8'($urandom);
        send(item);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_pointer_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.pointer_limit = value;
    endtask

    task automatic random_step();
        int base;
        int p;
        int label_len;
        int k;
        int nlab;
        int target;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            load($urandom_range(0, STORE_DEPTH - 1), 8'($urandom));
            return;
        end
        if (r == 1) begin
            decode($urandom_range(0, STORE_DEPTH - 1));
            return;
        end
        base = $urandom_range(40, STORE_DEPTH - 7);
        p = base;
        nlab = $urandom_range(0, 4);
        for (k = 0; k < nlab; k++) begin
            label_len = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 191)
                                                     : $urandom_range(1, 6);
            if (label_len > STORE_DEPTH - 3 - p) label_len = STORE_DEPTH - 3 - p;
            if (label_len < 1) break;
            load_label(p, label_len);
            p += label_len + 1;
        end
        r = $urandom_range(0, 9);
        if (r < 4) begin
            load(p, 8'h00);
        end else begin
            target = (r < 9) ? name_starts[$urandom_range(0, name_starts.size() - 1)]
                             : $urandom_range(0, 'h3FFF);
            load(p, PTR_TAG | 8'(target >> 8));
            load(p + 1, 8'(target));
        end
        name_starts.push_back(base);
        decode(base);
        if ($urandom_range(0, 1) == 1)
            decode(name_starts[$urandom_range(0, name_starts.size() - 1)]);
    endtask

    initial begin
        int phase;
        int phase_items;
        int phase_decodes;
        int i;
        sb = new();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // root, plain label with pointer-looking and dot bytes inside it,
        // pointer chain, label then pointer
        load(0, 8'h00);
        load(1, 8'd3);
        load(2, PTR_TAG);
        load(3, 8'h00);
        load(4, CHAR_DOT);
        load(5, 8'h00);
        load(6, PTR_TAG);
        load(7, 8'd1);
        load(8, 8'd1);
        load(9, 8'hFF);
        load(10, PTR_TAG);
        load(11, 8'd6);
        // self loop: ends on pointer limit or name length
        load_label(16, 8);
        load(25, PTR_TAG);
        load(26, 8'd16);
        // pointer to the top of the 14-bit space, pointer to the last byte
        load(28, 8'hFF);
        load(29, 8'hFF);
        load(30, 8'hC1);
        load(31, 8'hFF);
        // label running off the end of the store; last byte is a pointer tag
        load(506, 8'd7);
        for (i = 507; i <= 510; i++) load(i, 8'($urandom));
        load(511, PTR_TAG);
        // 64-byte label is still a plain label
        load_label(32, 64);
        load(97, PTR_TAG);
        load(98, 8'd1);
        name_starts = '{0, 1, 6, 8, 16, 32};

        decode(0);
        decode(1);
        decode(6);
        decode(8);
        decode(16);
        decode(28);
        decode(30);
        decode(506);
        decode(511);
        decode(32);
        write_pointer_limit('0);
        decode(6);
        decode(1);
        write_pointer_limit(LIMIT_W'(1));
        decode(8);
        decode(6);
        write_pointer_limit(LIMIT_W'(63));
        decode(16);
        decode(32);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_pointer_limit(LIMIT_W'($urandom_range(1, 4)));
                1: write_pointer_limit(LIMIT_W'(63));
                default: write_pointer_limit(LIMIT_W'($urandom_range(1, 63)));
            endcase
            phase_items = items_sent;
            phase_decodes = sb.decodes;
            while (items_sent - phase_items < 40 || sb.decodes - phase_decodes < 3)
                random_step();
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        $display("Run covered %0d byte loads and %0d decodes, %0d name words checked.",
                 sb.loads, sb.decodes, sb.words);
        $display("Decode outcomes ok/pointer limit/too long/out of store: %0d/%0d/%0d/%0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_PTR],
                 sb.status_hits[ST_LONG], sb.status_hits[ST_RANGE]);
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* dns_name_decompressor.f */
src/dnd_pkg.sv
src/dnd_walk.sv
src/dnd_emit.sv
src/dns_name_decompressor.sv
verif/tb_dns_name_decompressor.sv
